// ----- rtl/first_fit_block_allocator_unit_assert.svh -----
// assertion macros for the first-fit allocator checker
// depends on clk and rst_n being visible where a macro is used
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FFBA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffba assertion failed");

// next-cycle implication, disabled in reset
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffba assertion failed");

`endif

// ----- rtl/ffba_pkg.sv -----
// shared types and codes of the first-fit allocator
// no dependencies
`default_nettype none

package ffba_pkg;

    localparam int ADDR_W  = 20;
    localparam int SIZE_W  = 16;
    localparam int LIMIT_W = 21;

    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_ZALLOC = 2'd1;
    localparam logic [1:0] FUNC_RESIZE = 2'd2;
    localparam logic [1:0] FUNC_FREE   = 2'd3;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_FAIL = 2'd1;
    localparam logic [1:0] STAT_NOADDR = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              free;
    } entry_t;

endpackage

`default_nettype wire

// ----- rtl/ffba_cell.sv -----
// one table entry of the block chain, shifts toward its lower neighbor
// depends on ffba_pkg
`default_nettype none

module ffba_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift_en,
    input  wire ffba_pkg::entry_t d,
    output ffba_pkg::entry_t     q
);

    logic [ffba_pkg::ADDR_W-1:0] start_reg;
    logic [ffba_pkg::SIZE_W-1:0] size_reg;
    logic                        free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            free_reg <= d.free;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            start_reg <= d.start;
            size_reg  <= d.size;
        end
    end

    assign q = '{start: start_reg, size: size_reg, free: free_reg};

endmodule

`default_nettype wire

// ----- rtl/first_fit_block_allocator_unit.sv -----
// first-fit heap allocator: controller plus a rotating chain of table cells
// depends on ffba_pkg and ffba_cell
//
//  channel   handshake              payload
//  request   start / busy           func, size_bytes, count, addr
//  result    done (one cycle)       status, result_addr, copy_len, zero_fill, granted_size
//  config    apb psel/penable/...   heap_limit at address 0
//
// a request passes through the prep, scan, decide, update and done states in order:
// the table rotates once through the cell chain to search, once more to update
// busy stays high through the done cycle; results cannot be stalled
// reset clears the free marks, block count and heap break; heap_limit resets to 65536
`default_nettype none

module first_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] size_bytes,
    input  wire logic [15:0] count,
    input  wire logic [19:0] addr,
    output logic             done,
    output logic [1:0]       status,
    output logic [19:0]      result_addr,
    output logic [15:0]      copy_len,
    output logic             zero_fill,
    output logic [15:0]      granted_size,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = ffba_pkg::LIMIT_W + 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PREP   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_UPDATE = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [ffba_pkg::LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [ffba_pkg::LIMIT_W-1:0] break_reg;

    logic [1:0]  func_reg;
    logic [15:0] size_reg;
    logic [15:0] cnt_reg;
    logic [19:0] addr_reg;

    logic [15:0] need_reg;
    logic        need_ok_reg;
    logic [IDX_W-1:0] j_reg;

    logic             fit_found_reg;
    logic [IDX_W-1:0] fit_idx_reg;
    logic [19:0]      fit_start_reg;
    logic             lk_found_reg;
    logic [IDX_W-1:0] lk_idx_reg;
    logic [15:0]      lk_size_reg;

    logic             mark_fit_reg;
    logic             append_reg;
    logic [IDX_W-1:0] append_idx_reg;
    logic [19:0]      append_start_reg;
    logic             rel_mark_reg;

    logic [1:0]  status_reg;
    logic [19:0] result_addr_reg;
    logic [15:0] copy_len_reg;
    logic        zero_fill_reg;
    logic [15:0] granted_reg;

    ffba_pkg::entry_t cell_q [MAX_BLOCKS];
    ffba_pkg::entry_t tail_d;
    logic             shift_en;

    // ---------------- configuration port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ffba_pkg::LIMIT_W'(65536);
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            limit_reg <= pwdata[ffba_pkg::LIMIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {11'd0, limit_reg};

    // ---------------- cell chain ----------------
    assign shift_en = (state_reg == S_SCAN) || (state_reg == S_UPDATE);

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++)
        begin : g_cell
            if (g == MAX_BLOCKS - 1)
            begin : g_tail
                ffba_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .d        (tail_d),
                    .q        (cell_q[g])
                );
            end
            else
            begin : g_body
                ffba_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .d        (cell_q[g+1]),
                    .q        (cell_q[g])
                );
            end
        end
    endgenerate

    // head entry wraps around to the tail, edited during the update pass
    always_comb
    begin
        tail_d = cell_q[0];
        if (state_reg == S_UPDATE)
        begin
            if (mark_fit_reg && j_reg == fit_idx_reg)
            begin
                tail_d.free = 1'b0;
            end
            if (rel_mark_reg && j_reg == lk_idx_reg)
            begin
                tail_d.free = 1'b1;
            end
            if (append_reg && j_reg == append_idx_reg)
            begin
                tail_d = '{start: append_start_reg, size: need_reg, free: 1'b0};
            end
        end
    end

    // ---------------- search ----------------
    logic        in_range;
    logic        fit_hit;
    logic        lk_hit;
    logic        last_j;
    logic [31:0] prod;

    assign in_range = CNT_W'(j_reg) < count_reg;
    assign fit_hit  = in_range && !fit_found_reg && cell_q[0].free
                      && (cell_q[0].size >= need_reg);
    assign lk_hit   = in_range && !lk_found_reg && (cell_q[0].start == addr_reg);
    assign last_j   = (j_reg == IDX_W'(MAX_BLOCKS - 1));
    assign prod     = cnt_reg * size_reg;

    // ---------------- decision ----------------
    logic [ffba_pkg::LIMIT_W-1:0] lim;
    logic [SUM_W-1:0]             need_sum;
    logic                         app_ok;
    logic                         grab_ok;
    logic                         want_grab;
    logic                         rel_req;
    logic                         resize_move;
    logic                         use_append;
    logic [CNT_W-1:0]             count_after;
    logic                         rel_last;
    logic [1:0]                   d_status;
    logic [19:0]                  d_addr;
    logic [15:0]                  d_copy;
    logic                         d_zero;
    logic [15:0]                  d_granted;
    logic [19:0]                  grab_addr;

    assign lim      = limit_reg[20] ? ffba_pkg::LIMIT_W'(1048576) : limit_reg;
    assign need_sum = SUM_W'(break_reg) + SUM_W'(HEADER_BYTES) + SUM_W'(need_reg);
    assign app_ok   = (count_reg < CNT_W'(MAX_BLOCKS)) && (need_sum <= SUM_W'(lim));
    assign grab_addr = fit_found_reg ? fit_start_reg
                                     : 20'(break_reg + ffba_pkg::LIMIT_W'(HEADER_BYTES));

    always_comb
    begin
        want_grab   = 1'b0;
        rel_req     = 1'b0;
        resize_move = 1'b0;
        d_status    = ffba_pkg::STAT_FAIL;
        d_addr      = 20'd0;
        d_copy      = 16'd0;
        d_zero      = 1'b0;
        d_granted   = 16'd0;
        unique case (func_reg)
            ffba_pkg::FUNC_ALLOC, ffba_pkg::FUNC_ZALLOC:
            begin
                want_grab = 1'b1;
            end
            ffba_pkg::FUNC_RESIZE:
            begin
                priority if (addr_reg == 20'd0)
                begin
                    want_grab = 1'b1;
                end
                else if (size_reg == 16'd0)
                begin
                    d_status = ffba_pkg::STAT_FAIL;
                end
                else if (!lk_found_reg)
                begin
                    d_status = ffba_pkg::STAT_NOADDR;
                end
                else if (lk_size_reg >= size_reg)
                begin
                    d_status  = ffba_pkg::STAT_DONE;
                    d_addr    = addr_reg;
                    d_granted = size_reg;
                end
                else
                begin
                    want_grab   = 1'b1;
                    resize_move = 1'b1;
                end
            end
            ffba_pkg::FUNC_FREE:
            begin
                priority if (addr_reg == 20'd0)
                begin
                    d_status = ffba_pkg::STAT_DONE;
                end
                else if (!lk_found_reg)
                begin
                    d_status = ffba_pkg::STAT_NOADDR;
                end
                else
                begin
                    d_status = ffba_pkg::STAT_DONE;
                    rel_req  = 1'b1;
                end
            end
            default:
            begin
                d_status = ffba_pkg::STAT_FAIL;
            end
        endcase

        grab_ok = want_grab && need_ok_reg && (fit_found_reg || app_ok);
        if (grab_ok)
        begin
            d_status  = ffba_pkg::STAT_DONE;
            d_addr    = grab_addr;
            d_granted = need_reg;
            d_zero    = (func_reg == ffba_pkg::FUNC_ZALLOC);
            if (resize_move)
            begin
                rel_req = 1'b1;
                d_copy  = lk_size_reg;
            end
        end

        use_append  = grab_ok && !fit_found_reg;
        count_after = count_reg + CNT_W'(use_append);
        rel_last    = rel_req && ((CNT_W'(lk_idx_reg) + CNT_W'(1)) == count_after);
    end

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (start) state_next = S_PREP;
            S_PREP:   state_next = S_SCAN;
            S_SCAN:   if (last_j) state_next = S_DECIDE;
            S_DECIDE: state_next = S_UPDATE;
            S_UPDATE: if (last_j) state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            break_reg     <= '0;
            j_reg         <= '0;
            fit_found_reg <= 1'b0;
            lk_found_reg  <= 1'b0;
            mark_fit_reg  <= 1'b0;
            append_reg    <= 1'b0;
            rel_mark_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    j_reg         <= '0;
                    fit_found_reg <= 1'b0;
                    lk_found_reg  <= 1'b0;
                end
                S_SCAN, S_UPDATE:
                begin
                    j_reg <= last_j ? '0 : j_reg + IDX_W'(1);
                    if (state_reg == S_SCAN && fit_hit)
                    begin
                        fit_found_reg <= 1'b1;
                    end
                    if (state_reg == S_SCAN && lk_hit)
                    begin
                        lk_found_reg <= 1'b1;
                    end
                end
                S_DECIDE:
                begin
                    mark_fit_reg <= grab_ok && fit_found_reg;
                    append_reg   <= use_append;
                    rel_mark_reg <= rel_req && !rel_last;
                    if (rel_last)
                    begin
                        count_reg <= count_after - CNT_W'(1);
                        break_reg <= (addr_reg >= 20'(HEADER_BYTES))
                                     ? ffba_pkg::LIMIT_W'(addr_reg - 20'(HEADER_BYTES))
                                     : '0;
                    end
                    else if (use_append)
                    begin
                        count_reg <= count_after;
                        break_reg <= need_sum[ffba_pkg::LIMIT_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            func_reg <= func;
            size_reg <= size_bytes;
            cnt_reg  <= count;
            addr_reg <= addr;
        end
        if (state_reg == S_PREP)
        begin
            need_reg    <= (func_reg == ffba_pkg::FUNC_ZALLOC) ? prod[15:0] : size_reg;
            need_ok_reg <= (func_reg == ffba_pkg::FUNC_ZALLOC)
                           ? ((prod != 32'd0) && (prod[31:16] == 16'd0))
                           : (size_reg != 16'd0);
        end
        if (state_reg == S_SCAN && fit_hit)
        begin
            fit_idx_reg   <= j_reg;
            fit_start_reg <= cell_q[0].start;
        end
        if (state_reg == S_SCAN && lk_hit)
        begin
            lk_idx_reg  <= j_reg;
            lk_size_reg <= cell_q[0].size;
        end
        if (state_reg == S_DECIDE)
        begin
            append_idx_reg   <= count_reg[IDX_W-1:0];
            append_start_reg <= grab_addr;
            status_reg       <= d_status;
            result_addr_reg  <= d_addr;
            copy_len_reg     <= d_copy;
            zero_fill_reg    <= d_zero;
            granted_reg      <= d_granted;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign status       = status_reg;
    assign result_addr  = result_addr_reg;
    assign copy_len     = copy_len_reg;
    assign zero_fill    = zero_fill_reg;
    assign granted_size = granted_reg;

endmodule

`default_nettype wire

// ----- rtl/ffba_checker.sv -----
// port-level checks for the first-fit allocator, bound to the top level
// depends on first_fit_block_allocator_unit_assert.svh and ffba_pkg
`default_nettype none

`include "first_fit_block_allocator_unit_assert.svh"

module ffba_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [19:0] result_addr,
    input wire logic        zero_fill,
    input wire logic [15:0] granted_size
);

    // an accepted transaction keeps the unit busy
    `FFBA_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done)
    // a result ends the transaction
    `FFBA_ASSERT_NEXT(a_done_ends, done, !busy)
    `FFBA_ASSERT_NOW(a_done_busy, done, busy)
    // failures and misses grant nothing
    `FFBA_ASSERT_NOW(a_fail_empty, done && status != ffba_pkg::STAT_DONE,
        result_addr == 20'd0 && granted_size == 16'd0 && !zero_fill)
    `FFBA_ASSERT_NOW(a_zero_grant, done && zero_fill, granted_size != 16'd0)

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .result_addr  (result_addr),
    .zero_fill    (zero_fill),
    .granted_size (granted_size)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
// testbench for the first-fit heap allocator: directed and random requests,
// apb writes of heap_limit, a local table model predicts each result
// depends on ffba_pkg and the first_fit_block_allocator_unit rtl
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBLK = 64;
    localparam int HDR = 16;
    localparam int SPACE = 1048576;
    localparam int LATENCY = 2 * NBLK + 3;
    localparam int WATCHDOG = 20000;
    localparam logic [2:0] REG_HEAP_LIMIT = 3'd0;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] result_addr;
        logic [15:0] copy_len;
        logic        zero_fill;
        logic [15:0] granted_size;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  func = ffba_pkg::FUNC_ALLOC;
    logic [15:0] size_bytes = '0;
    logic [15:0] count = '0;
    logic [19:0] addr = '0;
    logic        done;
    logic [1:0]  status;
    logic [19:0] result_addr;
    logic [15:0] copy_len;
    logic        zero_fill;
    logic [15:0] granted_size;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    first_fit_block_allocator_unit #(.MAX_BLOCKS(NBLK), .HEADER_BYTES(HDR)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .size_bytes(size_bytes), .count(count), .addr(addr),
        .done(done), .status(status), .result_addr(result_addr),
        .copy_len(copy_len), .zero_fill(zero_fill), .granted_size(granted_size),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the allocator table
    int unsigned limit_bytes;
    int unsigned blk_start [NBLK];
    int unsigned blk_size [NBLK];
    bit          blk_free [NBLK];
    int unsigned nblocks;
    int unsigned brk;

    outcome_t pending_results [$];
    int       errors = 0;
    int       idle_cycles = 0;
    int       send_idle_pct = 0;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("tb_top: mismatch %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic bit take_block(input int unsigned sz, output int unsigned where);
        int unsigned need;
        int unsigned lim;
        where = 0;
        if (sz == 0) return 0;
        for (int i = 0; i < nblocks; i++)
        begin
            if (blk_free[i] && blk_size[i] >= sz)
            begin
                blk_free[i] = 0;
                where = blk_start[i];
                return 1;
            end
        end
        if (nblocks >= NBLK) return 0;
        lim = (limit_bytes > SPACE) ? SPACE : limit_bytes;
        need = brk + HDR + sz;
        if (need > lim) return 0;
        blk_start[nblocks] = brk + HDR;
        blk_size[nblocks] = sz;
        blk_free[nblocks] = 0;
        where = brk + HDR;
        nblocks++;
        brk = need;
        return 1;
    endfunction

    function automatic int find_block(input int unsigned a);
        for (int i = 0; i < nblocks; i++)
            if (blk_start[i] == a) return i;
        return -1;
    endfunction

    function automatic void drop_block(input int unsigned i);
        if (i + 1 == nblocks)
        begin
            brk = (blk_start[i] >= HDR) ? blk_start[i] - HDR : 0;
            nblocks--;
        end
        else
            blk_free[i] = 1;
    endfunction

    function automatic outcome_t predict_request(input logic [1:0] f, input int unsigned sz,
                                                  input int unsigned cnt, input int unsigned a);
        outcome_t o;
        int unsigned where;
        int unsigned prod;
        int unsigned old;
        int idx;
        o = '{status: ffba_pkg::STAT_FAIL, default: '0};
        case (f)
            ffba_pkg::FUNC_ALLOC:
                if (take_block(sz, where))
                    o = '{ffba_pkg::STAT_DONE, where[19:0], 16'd0, 1'b0, sz[15:0]};
            ffba_pkg::FUNC_ZALLOC:
            begin
                prod = cnt * sz;
                if (cnt != 0 && sz != 0 && prod <= 65535 && take_block(prod, where))
                    o = '{ffba_pkg::STAT_DONE, where[19:0], 16'd0, 1'b1, prod[15:0]};
            end
            ffba_pkg::FUNC_RESIZE:
            begin
                if (a == 0)
                begin
                    if (take_block(sz, where))
                        o = '{ffba_pkg::STAT_DONE, where[19:0], 16'd0, 1'b0, sz[15:0]};
                end
                else if (sz != 0)
                begin
                    idx = find_block(a);
                    if (idx < 0)
                        o.status = ffba_pkg::STAT_NOADDR;
                    else
                    begin
                        old = blk_size[idx];
                        if (old >= sz)
                            o = '{ffba_pkg::STAT_DONE, a[19:0], 16'd0, 1'b0, sz[15:0]};
                        else if (take_block(sz, where))
                        begin
                            drop_block(idx);
                            o = '{ffba_pkg::STAT_DONE, where[19:0], old[15:0], 1'b0,
                                  sz[15:0]};
                        end
                    end
                end
            end
            default:
            begin
                if (a == 0)
                    o.status = ffba_pkg::STAT_DONE;
                else
                begin
                    idx = find_block(a);
                    if (idx < 0)
                        o.status = ffba_pkg::STAT_NOADDR;
                    else
                    begin
                        drop_block(idx);
                        o.status = ffba_pkg::STAT_DONE;
                    end
                end
            end
        endcase
        return o;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("tb_top: result with nothing outstanding");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status) report_mismatch("status", status, want.status);
                if (result_addr !== want.result_addr)
                    report_mismatch("result_addr", result_addr, want.result_addr);
                if (copy_len !== want.copy_len)
                    report_mismatch("copy_len", copy_len, want.copy_len);
                if (zero_fill !== want.zero_fill)
                    report_mismatch("zero_fill", zero_fill, want.zero_fill);
                if (granted_size !== want.granted_size)
                    report_mismatch("granted_size", granted_size, want.granted_size);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] f, input int unsigned sz,
                                input int unsigned cnt, input int unsigned a);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        start <= 1'b1;
        func <= f;
        size_bytes <= sz[15:0];
        count <= cnt[15:0];
        addr <= a[19:0];
        do @(posedge clk); while (busy);
        pending_results.push_back(predict_request(f, sz, cnt, a));
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_heap_limit(input int unsigned v);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_HEAP_LIMIT;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        limit_bytes = v & 32'h1F_FFFF;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // an address of a live block most of the time, else a random one
    function automatic int unsigned pick_addr();
        int r;
        r = $urandom_range(99);
        if (nblocks != 0 && r < 80) return blk_start[$urandom_range(nblocks - 1)];
        if (r < 88) return 0;
        return $urandom_range(20'hF_FFFF);
    endfunction

    function automatic int unsigned pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 256);
        if (r < 90) return $urandom_range(1, 4096);
        if (r < 95) return 0;
        return $urandom_range(16'hFFFF);
    endfunction

    task automatic test_directed();
        int unsigned a0;
        send_request(ffba_pkg::FUNC_ALLOC, 0, 0, 0);
        send_request(ffba_pkg::FUNC_ALLOC, 100, 0, 0);
        a0 = HDR;
        send_request(ffba_pkg::FUNC_ALLOC, 200, 16'hFFFF, 20'hF_FFFF);
        send_request(ffba_pkg::FUNC_ALLOC, 65535, 0, 0);
        send_request(ffba_pkg::FUNC_ZALLOC, 10, 0, 0);
        send_request(ffba_pkg::FUNC_ZALLOC, 0, 10, 0);
        send_request(ffba_pkg::FUNC_ZALLOC, 256, 256, 0);
        send_request(ffba_pkg::FUNC_ZALLOC, 8, 4, 0);
        send_request(ffba_pkg::FUNC_ZALLOC, 1, 65535, 0);
        send_request(ffba_pkg::FUNC_RESIZE, 50, 0, 0);
        send_request(ffba_pkg::FUNC_RESIZE, 0, 0, a0);
        send_request(ffba_pkg::FUNC_RESIZE, 80, 0, a0);
        send_request(ffba_pkg::FUNC_RESIZE, 300, 0, a0);
        send_request(ffba_pkg::FUNC_RESIZE, 10, 0, 20'hF_FFFF);
        send_request(ffba_pkg::FUNC_FREE, 0, 0, 0);
        send_request(ffba_pkg::FUNC_FREE, 0, 0, 20'hF_FFF0);
        send_request(ffba_pkg::FUNC_FREE, 0, 0, a0);
        send_request(ffba_pkg::FUNC_FREE, 0, 0, a0);
        send_request(ffba_pkg::FUNC_ALLOC, 60, 0, 0);
        if (nblocks != 0) send_request(ffba_pkg::FUNC_FREE, 0, 0, blk_start[nblocks - 1]);
        send_request(ffba_pkg::FUNC_ALLOC, 16'hFFFF, 16'hFFFF, 20'hF_FFFF);
    endtask

    task automatic test_random(input int n);
        int unsigned sz;
        int unsigned f;
        for (int i = 0; i < n; i++)
        begin
            f = $urandom_range(99);
            sz = pick_size();
            if (f < 35)
                send_request(ffba_pkg::FUNC_ALLOC, sz, $urandom_range(16'hFFFF),
                             $urandom_range(20'hF_FFFF));
            else if (f < 45)
                send_request(ffba_pkg::FUNC_ZALLOC, $urandom_range(1, 64),
                             $urandom_range(0, 64), $urandom_range(20'hF_FFFF));
            else if (f < 50)
                send_request(ffba_pkg::FUNC_ZALLOC, $urandom_range(16'hFFFF),
                             $urandom_range(16'hFFFF), 0);
            else if (f < 70)
                send_request(ffba_pkg::FUNC_RESIZE, sz, $urandom_range(16'hFFFF),
                             pick_addr());
            else
                send_request(ffba_pkg::FUNC_FREE, $urandom_range(16'hFFFF),
                             $urandom_range(16'hFFFF), pick_addr());
        end
    endtask

    // fill the table to capacity with small blocks, overflow it, then empty it from the top
    task automatic test_table_full();
        for (int i = 0; i < NBLK + 4; i++)
            send_request(ffba_pkg::FUNC_ALLOC, $urandom_range(1, 32), 0, 0);
        while (nblocks != 0)
            send_request(ffba_pkg::FUNC_FREE, 0, 0, blk_start[nblocks - 1]);
    endtask

    initial
    begin
        limit_bytes = 65536;
        nblocks = 0;
        brk = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        test_random(150);
        send_idle_pct = 74;
        test_random(150);
        // hold off until every outstanding result is back
        wait_drained();
        write_heap_limit(0);
        test_random(50);
        write_heap_limit(2000);
        test_random(200);
        write_heap_limit(1048576);
        send_idle_pct = 33;
        test_random(200);
        write_heap_limit(21'h1F_FFFF);
        send_idle_pct = 0;
        test_table_full();
        write_heap_limit(65536);
        test_random(200);

        wait_drained();
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/ffba_pkg.sv
rtl/ffba_cell.sv
rtl/first_fit_block_allocator_unit.sv
rtl/ffba_checker.sv
dv/tb_top.sv
